@@ rtl/scu_pkg.sv @@
// ----------------------------------------------------------------------------
// scu_pkg: shared constants, types and rounding helpers
// Fixed-point formats and constants for the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package scu_pkg;

  localparam int AngleFracBits = 18;
  localparam int OutFracBits   = 30;

  // octant index width follows from the largest magnitude 2^(31 - AngleFracBits)
  localparam int JW = 32 - AngleFracBits;

  localparam logic [63:0] FourOverPiQ32 = 64'h0000_0001_45F3_06DD;
  localparam logic [31:0] FourOverPiLo  = FourOverPiQ32[31:0];
  localparam logic [63:0] PiOver4Q60    = 64'h0C90_FDAA_2216_8C23;
  localparam logic [29:0] PiHi          = 30'(PiOver4Q60 >> 30);
  localparam logic [29:0] PiLo          = PiOver4Q60[29:0];

  localparam logic signed [31:0] CosK1 = 32'sd52470;
  localparam logic signed [31:0] CosK2 = 32'sd2982278;
  localparam logic signed [31:0] CosK3 = 32'sd89478440;
  localparam logic signed [31:0] SinK1 = 32'sd419088;
  localparam logic signed [31:0] SinK2 = 32'sd17893179;
  localparam logic signed [31:0] SinK3 = 32'sd357913682;
  localparam logic signed [33:0] OneQ31 = 34'sd2147483648;

  typedef struct packed {
    logic sin_neg;
    logic cos_neg;
    logic swap;
  } oct_flags_t;

  // round to nearest, halves away from zero; s >= 1
  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m   = neg ? (64'd0 - 64'(v)) : 64'(v);
    m   = (m + (64'd1 << (s - 1))) >> s;
    return neg ? $signed(64'd0 - m) : $signed(m);
  endfunction

  function automatic logic [31:0] finish(logic signed [33:0] v, logic neg);
    logic signed [63:0] o;
    logic signed [63:0] lim;
    lim = 64'sd1 <<< OutFracBits;
    o   = round_shift(64'(v), 31 - OutFracBits);
    if (neg) begin
      o = -o;
    end
    if (o > lim) begin
      o = lim;
    end
    if (o < -lim) begin
      o = -lim;
    end
    return o[31:0];
  endfunction

endpackage

@@ rtl/scu_if.sv @@
// ----------------------------------------------------------------------------
// scu_angle_if / scu_result_if: valid/ready channels
// Angle input channel and sine/cosine result channel.
// ----------------------------------------------------------------------------
interface scu_angle_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface scu_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] sine;
  logic [31:0] cosine;
  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

@@ rtl/scu_reduce.sv @@
// ----------------------------------------------------------------------------
// scu_reduce: octant selection and argument reduction
// Five stages: magnitude, 4/pi product, octant index, index*pi/4, reduced r.
// ----------------------------------------------------------------------------
module scu_reduce (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          angle_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   r_o,
  output scu_pkg::oct_flags_t  flags_o
);

  localparam int NS = 5;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: sign and magnitude
  logic        neg1_q;
  logic [31:0] mag1_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      neg1_q <= angle_i[31];
      mag1_q <= angle_i[31] ? (32'd0 - angle_i) : angle_i;
    end
  end

  // stage 2: low part of mag * 4/pi
  logic        neg2_q;
  logic [31:0] mag2_q;
  logic [63:0] prod2_q;
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      neg2_q  <= neg1_q;
      mag2_q  <= mag1_q;
      prod2_q <= 64'(mag1_q) * 64'(scu_pkg::FourOverPiLo);
    end
  end

  // stage 3: octant index, rounded up to even
  logic [63:0]              sum3;
  logic [scu_pkg::JW-1:0]   j3;
  logic [scu_pkg::JW-1:0]   je3;
  scu_pkg::oct_flags_t      fl3;
  always_comb begin
    sum3 = prod2_q + (64'(mag2_q) << 32);
    j3   = scu_pkg::JW'(sum3 >> (scu_pkg::AngleFracBits + 32));
    je3  = j3 + scu_pkg::JW'(j3[0]);
    fl3.sin_neg = neg2_q ^ je3[2];
    fl3.cos_neg = je3[2] ^ je3[1];
    fl3.swap    = je3[1] ^ je3[0];
  end

  logic [scu_pkg::JW-1:0] j3_q;
  logic [31:0]            mag3_q;
  scu_pkg::oct_flags_t    fl3_q;
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      j3_q   <= je3;
      mag3_q <= mag2_q;
      fl3_q  <= fl3;
    end
  end

  // stage 4: index * pi/4 in two partial products
  logic [63:0]         ph4_q;
  logic [63:0]         pl4_q;
  logic [31:0]         mag4_q;
  scu_pkg::oct_flags_t fl4_q;
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ph4_q  <= 64'(j3_q) * 64'(scu_pkg::PiHi);
      pl4_q  <= 64'(j3_q) * 64'(scu_pkg::PiLo);
      mag4_q <= mag3_q;
      fl4_q  <= fl3_q;
    end
  end

  // stage 5: reduced argument, wrapped Q60 rounded to Q31
  logic [63:0]        ru5;
  logic signed [63:0] r5;
  always_comb begin
    ru5 = (64'(mag4_q) << (60 - scu_pkg::AngleFracBits)) - ((ph4_q << 30) + pl4_q);
    r5  = scu_pkg::round_shift($signed(ru5), 29);
  end

  logic signed [31:0]  r5_q;
  scu_pkg::oct_flags_t fl5_q;
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      r5_q  <= r5[31:0];
      fl5_q <= fl4_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign r_o         = r5_q;
  assign flags_o     = fl5_q;

endmodule

@@ rtl/scu_poly.sv @@
// ----------------------------------------------------------------------------
// scu_poly: sine and cosine polynomial evaluation
// Six stages: r*r, z terms, two Horner steps, sums, swap/sign/saturate.
// ----------------------------------------------------------------------------
module scu_poly (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   r_i,
  input  scu_pkg::oct_flags_t  flags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          sine_o,
  output logic [31:0]          cosine_o
);

  localparam int NS = 6;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage A: r*r
  logic signed [63:0]  prr_q;
  logic signed [31:0]  ra_q;
  scu_pkg::oct_flags_t fa_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prr_q <= r_i * r_i;
      ra_q  <= r_i;
      fa_q  <= flags_i;
    end
  end

  // stage B: z, then K1*z for both polynomials, z*z, z*r
  logic signed [31:0] zb;
  logic signed [63:0] zb_full;
  assign zb_full = scu_pkg::round_shift(prr_q, 31);
  assign zb      = zb_full[31:0];

  logic signed [63:0]  p1_q, q1_q, pzz_q, pzr_q;
  logic signed [31:0]  zb_q, rb_q;
  scu_pkg::oct_flags_t fb_q;
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_q  <= scu_pkg::CosK1 * zb;
      q1_q  <= scu_pkg::SinK1 * zb;
      pzz_q <= zb * zb;
      pzr_q <= zb * ra_q;
      zb_q  <= zb;
      rb_q  <= ra_q;
      fb_q  <= fa_q;
    end
  end

  // stage C: first Horner step of both polynomials
  logic signed [63:0] t1, t1s, zz_full, zr_full;
  logic signed [31:0] c1a, c2a;
  always_comb begin
    t1      = scu_pkg::round_shift(p1_q, 31);
    t1s     = scu_pkg::round_shift(q1_q, 31);
    c1a     = t1[31:0] - scu_pkg::CosK2;
    c2a     = scu_pkg::SinK2 - t1s[31:0];
    zz_full = scu_pkg::round_shift(pzz_q, 31);
    zr_full = scu_pkg::round_shift(pzr_q, 31);
  end

  logic signed [63:0]  p2_q, q2_q;
  logic signed [31:0]  zz_q, zr_q, zc_q, rc_q;
  scu_pkg::oct_flags_t fc_q;
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p2_q <= c1a * zb_q;
      q2_q <= c2a * zb_q;
      zz_q <= zz_full[31:0];
      zr_q <= zr_full[31:0];
      zc_q <= zb_q;
      rc_q <= rb_q;
      fc_q <= fb_q;
    end
  end

  // stage D: second Horner step, scale by z^2 and z*r
  logic signed [63:0] t2, t3;
  logic signed [31:0] c1b, c2b;
  always_comb begin
    t2  = scu_pkg::round_shift(p2_q, 31);
    t3  = scu_pkg::round_shift(q2_q, 31);
    c1b = t2[31:0] + scu_pkg::CosK3;
    c2b = t3[31:0] - scu_pkg::SinK3;
  end

  logic signed [63:0]  p3_q, q3_q;
  logic signed [31:0]  zd_q, rd_q;
  scu_pkg::oct_flags_t fd_q;
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p3_q <= c1b * zz_q;
      q3_q <= c2b * zr_q;
      zd_q <= zc_q;
      rd_q <= rc_q;
      fd_q <= fc_q;
    end
  end

  // stage E: close both polynomials
  logic signed [63:0] t4, t5, zh;
  logic signed [33:0] c1e, c2e;
  always_comb begin
    t4  = scu_pkg::round_shift(p3_q, 31);
    t5  = scu_pkg::round_shift(q3_q, 31);
    zh  = scu_pkg::round_shift(64'(zd_q), 1);
    c1e = t4[33:0] - zh[33:0] + scu_pkg::OneQ31;
    c2e = t5[33:0] + 34'(rd_q);
  end

  logic signed [33:0]  c1_q, c2_q;
  scu_pkg::oct_flags_t fe_q;
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      c1_q <= c1e;
      c2_q <= c2e;
      fe_q <= fd_q;
    end
  end

  // stage F: swap, sign, saturate
  logic [31:0] sine_q, cosine_q;
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sine_q   <= scu_pkg::finish(fe_q.swap ? c1_q : c2_q, fe_q.sin_neg);
      cosine_q <= scu_pkg::finish(fe_q.swap ? c2_q : c1_q, fe_q.cos_neg);
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign sine_o      = sine_q;
  assign cosine_o    = cosine_q;

endmodule

@@ rtl/sine_cosine_unit.sv @@
// ----------------------------------------------------------------------------
// sine_cosine_unit: pipelined fixed-point sine and cosine
// Eleven register stages lie between the angle transfer and the result valid;
// one angle per cycle.
// Throughput is one per cycle while the receiver keeps ready high.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// Stall: each stage holds while its successor is full and not advancing.
// ----------------------------------------------------------------------------
module sine_cosine_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  scu_angle_if.sink    angle_i,
  scu_result_if.source result_o
);

  // handoff between argument reduction and polynomial evaluation
  logic                r_valid;
  logic                r_ready;
  logic signed [31:0]  r_val;
  scu_pkg::oct_flags_t r_flags;

  // reduce |angle| by the even octant index times pi/4, derive signs and swap
  scu_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (angle_i.valid),
    .in_ready_o  (angle_i.ready),
    .angle_i     (angle_i.angle),
    .out_valid_o (r_valid),
    .out_ready_i (r_ready),
    .r_o         (r_val),
    .flags_o     (r_flags)
  );

  // evaluate both polynomials, then swap and sign per octant
  scu_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (r_valid),
    .in_ready_o  (r_ready),
    .r_i         (r_val),
    .flags_i     (r_flags),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sine_o      (result_o.sine),
    .cosine_o    (result_o.cosine)
  );

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for sine_cosine_unit
// Drives angles through the valid/ready input channel, predicts each sine and
// cosine pair in fixed point, and compares every result transfer in order.
// A short table of directed angles is followed by random ones under three
// idling profiles and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Latency     = 11;
  localparam int RandomCount = 1530;

  typedef struct {
    logic [31:0] angle;
    logic        typed;   // expected pair typed in below
    logic [31:0] sine;
    logic [31:0] cosine;
  } angle_row_t;

  typedef struct {
    logic [31:0] sine;
    logic [31:0] cosine;
  } sincos_t;

  logic clk_i;
  logic rst_ni;

  scu_angle_if  angle_ch ();
  scu_result_if result_ch ();

  sine_cosine_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .angle_i (angle_ch),
    .result_o(result_ch)
  );

  sincos_t pending_q[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  logic    recv_hold;
  logic    stim_done;

  // 1.0 in the output format
  localparam logic [31:0] OutOne    = 32'(64'sd1 <<< scu_pkg::OutFracBits);

  angle_row_t dir_table[20] = '{
    '{32'h0000_0000, 1'b1, 32'h0, OutOne},            // zero angle
    '{32'h0000_0001, 1'b0, 32'h0, 32'h0},             // smallest positive
    '{32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},             // smallest negative
    '{32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},             // largest positive
    '{32'h8000_0000, 1'b0, 32'h0, 32'h0},             // largest magnitude
    '{32'h0000_C910, 1'b0, 32'h0, 32'h0},             // near pi/16
    '{32'h0000_C90F, 1'b0, 32'h0, 32'h0},
    '{32'h0000_C911, 1'b0, 32'h0, 32'h0},
    '{32'h0001_921F, 1'b0, 32'h0, 32'h0},             // near pi/8
    '{32'h0002_5B2F, 1'b0, 32'h0, 32'h0},             // near 3pi/16
    '{32'h0003_243F, 1'b0, 32'h0, 32'h0},             // near pi/4
    '{32'h0003_ED4F, 1'b0, 32'h0, 32'h0},             // near 5pi/16
    '{32'h0004_B65F, 1'b0, 32'h0, 32'h0},             // near 3pi/8
    '{32'h0005_7F6E, 1'b0, 32'h0, 32'h0},             // near 7pi/16
    '{32'h0006_487F, 1'b0, 32'h0, 32'h0},             // near pi/2
    '{32'hFFFC_DBC1, 1'b0, 32'h0, 32'h0},             // near -pi/4
    '{32'hFFFE_6DE1, 1'b0, 32'h0, 32'h0},             // near -pi/8
    '{32'h5555_5555, 1'b0, 32'h0, 32'h0},             // alternating bits
    '{32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0},
    '{32'h0004_0000, 1'b0, 32'h0, 32'h0}              // 1.0 rad
  };

  // round to nearest, halves away from zero
  function automatic longint rnd_shift(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint qmul31(longint a, longint b);
    return rnd_shift(a * b, 31);
  endfunction

  function automatic logic [31:0] to_out(longint v, logic neg);
    longint o;
    longint lim;
    lim = longint'(1) <<< scu_pkg::OutFracBits;
    o = rnd_shift(v, 31 - scu_pkg::OutFracBits);
    if (neg) begin
      o = -o;
    end
    if (o > lim) begin
      o = lim;
    end
    if (o < -lim) begin
      o = -lim;
    end
    return o[31:0];
  endfunction

  // predict the sine/cosine pair for one angle
  function automatic sincos_t predict_sincos(logic [31:0] angle);
    logic            neg;
    logic            upper;
    logic            sin_neg;
    logic            cos_neg;
    longint unsigned mag;
    longint unsigned oct_idx;
    longint unsigned oct;
    longint unsigned ru;
    longint          r;
    longint          z;
    longint          cpoly;
    longint          spoly;
    sincos_t         res;
    neg = angle[31];
    mag = neg ? (64'h1_0000_0000 - {32'h0, angle}) : {32'h0, angle};
    oct_idx = (mag * scu_pkg::FourOverPiQ32) >> (scu_pkg::AngleFracBits + 32);
    if (oct_idx[0]) begin
      oct_idx = oct_idx + 1;
    end
    oct = oct_idx & 7;
    upper = oct > 3;
    if (upper) begin
      oct = oct - 4;
    end
    sin_neg = neg != upper;
    cos_neg = upper != (oct > 1);
    ru = (mag << (60 - scu_pkg::AngleFracBits)) - oct_idx * scu_pkg::PiOver4Q60;
    r = rnd_shift(longint'(ru), 29);
    z = qmul31(r, r);
    cpoly = qmul31(longint'(scu_pkg::CosK1), z) - longint'(scu_pkg::CosK2);
    cpoly = qmul31(cpoly, z) + longint'(scu_pkg::CosK3);
    cpoly = qmul31(cpoly, qmul31(z, z));
    cpoly = cpoly - rnd_shift(z, 1) + 64'sd2147483648;
    spoly = -longint'(scu_pkg::SinK1);
    spoly = qmul31(spoly, z) + longint'(scu_pkg::SinK2);
    spoly = qmul31(spoly, z) - longint'(scu_pkg::SinK3);
    spoly = qmul31(spoly, qmul31(z, r)) + r;
    if (oct == 1 || oct == 2) begin
      res.sine   = to_out(cpoly, sin_neg);
      res.cosine = to_out(spoly, cos_neg);
    end else begin
      res.sine   = to_out(spoly, sin_neg);
      res.cosine = to_out(cpoly, cos_neg);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // offer one angle and hold it until the transfer; drop valid while idling
  task automatic send_angle(logic [31:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= angle;
    do begin
      @(posedge clk_i);
    end while (!angle_ch.ready);
  endtask

  // random angle: mostly within +/-pi/2, some full range, some boundaries
  function automatic logic [31:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      return 32'($signed($urandom_range(32'h000C_90FE))) - 32'sh0006_487F;
    end else if (pick < 7) begin
      return $urandom;
    end else if (pick < 9) begin
      // near a multiple of pi/16
      return 32'((64'($urandom_range(40)) * 64'h0000_C90F_DAA2) >> 16)
             + 32'($urandom_range(4)) - 32'd2 ^ {32{pick[0]}};
    end
    return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFF0} | 32'($urandom_range(15));
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // limit: far above the slowest correct run
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random ready, forced low during a hold-off
  always @(posedge clk_i) begin
    result_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // check every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    sincos_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected sine", result_ch.sine, 32'h0);
      end else begin
        want = pending_q.pop_front();
        if (result_ch.sine !== want.sine) begin
          report_mismatch("sine", result_ch.sine, want.sine);
        end
        if (result_ch.cosine !== want.cosine) begin
          report_mismatch("cosine", result_ch.cosine, want.cosine);
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    int holdoff_cycles;
    recv_hold = 1'b0;
    wait (stim_done === 1'b0 && rst_ni === 1'b1);
    repeat (400) @(posedge clk_i);
    recv_hold <= 1'b1;
    for (holdoff_cycles = 0; holdoff_cycles < 60; holdoff_cycles++) begin
      @(posedge clk_i);
    end
    recv_hold <= 1'b0;
  end

  initial begin
    int      n;
    int      drain;
    sincos_t want;
    error_count     = 0;
    stim_done       = 1'b0;
    send_idle_pct   = 31;
    recv_idle_pct   = 57;
    rst_ni          = 1'b0;
    angle_ch.valid  = 1'b0;
    angle_ch.angle  = '0;
    result_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; the expectation is queued before the transfer lands
    foreach (dir_table[i]) begin
      if (dir_table[i].typed) begin
        want.sine   = dir_table[i].sine;
        want.cosine = dir_table[i].cosine;
      end else begin
        want = predict_sincos(dir_table[i].angle);
      end
      pending_q.push_back(want);
      send_angle(dir_table[i].angle);
    end
    // zero angle again: cosine at the top of the output range
    pending_q.push_back(predict_sincos(32'h0000_0000));
    send_angle(32'h0000_0000);

    for (n = 0; n < RandomCount; n++) begin
      logic [31:0] a;
      if (n == RandomCount / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 31;
      end else if (n == 2 * RandomCount / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      a = random_angle();
      pending_q.push_back(predict_sincos(a));
      send_angle(a);
    end
    angle_ch.valid <= 1'b0;
    stim_done = 1'b1;

    // drain: wait until every expectation has arrived, then idle before the final check
    for (drain = 0; pending_q.size() != 0 && drain < 100000; drain++) begin
      @(posedge clk_i);
    end
    repeat (Latency + 4) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $display("%0d results never arrived", pending_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
